### design/bsm_pkg.sv
`default_nettype none

package bsm_pkg;

  // Field widths.
  localparam int unsigned CoordW = 7;
  localparam int unsigned SizeW  = 7;
  localparam int unsigned ShapeW = 4;
  localparam int unsigned DiamW  = 2 * SizeW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;

  // Largest brush size that a width or height register may take.
  localparam logic [7:0] MaxSize = 8'd127;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegShape  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd2;

  // Shape codes.
  localparam logic [ShapeW-1:0] ShapeRound      = 4'd0;
  localparam logic [ShapeW-1:0] ShapeSquare     = 4'd1;
  localparam logic [ShapeW-1:0] ShapeSieveRound = 4'd2;
  localparam logic [ShapeW-1:0] ShapeSieveSq    = 4'd3;
  localparam logic [ShapeW-1:0] ShapePlus       = 4'd4;
  localparam logic [ShapeW-1:0] ShapeSlash      = 4'd5;
  localparam logic [ShapeW-1:0] ShapeAntislash  = 4'd6;
  localparam logic [ShapeW-1:0] ShapeHbar       = 4'd7;
  localparam logic [ShapeW-1:0] ShapeVbar       = 4'd8;
  localparam logic [ShapeW-1:0] ShapeCross      = 4'd9;
  localparam logic [ShapeW-1:0] ShapeDiamond    = 4'd10;
  localparam logic [ShapeW-1:0] ShapeNone       = 4'd11;

  // Brush setup as seen by the pixel evaluator.
  typedef struct packed {
    logic [ShapeW-1:0] shape;
    logic [SizeW-1:0]  width;
    logic [SizeW-1:0]  height;
    logic [DiamW-1:0]  diam2;
  } bsm_cfg_t;

  // Clamp a size to the range one through MaxSize.
  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) begin
      r = SizeW'(1);
    end else if ({1'b0, v} > MaxSize) begin
      r = MaxSize[SizeW-1:0];
    end
    return r;
  endfunction

  // Squared diameter with the fixed corrections for a few small sizes.
  function automatic logic [DiamW-1:0] squared_diameter(input logic [SizeW-1:0] d);
    logic [DiamW-1:0] sq;
    logic [DiamW-1:0] r;
    sq = DiamW'(d) * DiamW'(d);
    case (d)
      SizeW'(3), SizeW'(9): r = sq - DiamW'(2);
      SizeW'(11):           r = sq - DiamW'(6);
      SizeW'(14):           r = sq - DiamW'(4);
      default:              r = sq;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### design/bsm_cfg.sv
`default_nettype none

module bsm_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bsm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [bsm_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output bsm_pkg::bsm_cfg_t                   cfg_o
);

  logic [bsm_pkg::ShapeW-1:0] shape_q;
  logic [bsm_pkg::SizeW-1:0]  width_q;
  logic [bsm_pkg::SizeW-1:0]  height_q;
  logic [bsm_pkg::DiamW-1:0]  diam2_q;
  logic [bsm_pkg::SizeW-1:0]  size_in;

  // Sizes are clamped as they are written.
  assign size_in = bsm_pkg::clamp_size(cfg_wdata_i[bsm_pkg::SizeW-1:0]);

  // Register file; the squared diameter is kept alongside the width so the
  // pixel path needs no extra multiplier.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= bsm_pkg::ShapeRound;
      width_q  <= bsm_pkg::SizeW'(1);
      height_q <= bsm_pkg::SizeW'(1);
      diam2_q  <= bsm_pkg::DiamW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bsm_pkg::RegShape: begin
          shape_q <= cfg_wdata_i[bsm_pkg::ShapeW-1:0];
        end
        bsm_pkg::RegWidth: begin
          width_q <= size_in;
          diam2_q <= bsm_pkg::squared_diameter(size_in);
        end
        bsm_pkg::RegHeight: begin
          height_q <= size_in;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o.shape  = shape_q;
  assign cfg_o.width  = width_q;
  assign cfg_o.height = height_q;
  assign cfg_o.diam2  = diam2_q;

endmodule

`default_nettype wire

### design/bsm_eval.sv
`default_nettype none

module bsm_eval (
  input  wire logic [bsm_pkg::CoordW-1:0] col_i,
  input  wire logic [bsm_pkg::CoordW-1:0] row_i,
  input  wire bsm_pkg::bsm_cfg_t          cfg_i,
  output logic                            hit_o
);

  logic [bsm_pkg::SizeW-1:0]    w;
  logic [bsm_pkg::SizeW-1:0]    h;
  logic [bsm_pkg::SizeW-2:0]    half;
  logic signed [8:0]            x;
  logic signed [8:0]            y;
  logic [7:0]                   ax;
  logic [7:0]                   ay;
  logic [15:0]                  xx;
  logic [15:0]                  yy;
  logic [16:0]                  dist2;
  logic [16:0]                  diam2;
  logic                         in_rect;
  logic                         parity;
  logic [7:0]                   slash_col;
  logic [7:0]                   cross_col;
  logic [bsm_pkg::CoordW-1:0]   dc;
  logic [bsm_pkg::CoordW-1:0]   dr;
  logic [7:0]                   dsum;
  logic                         shape_hit;

  assign w     = cfg_i.width;
  assign h     = cfg_i.height;
  assign half  = w[bsm_pkg::SizeW-1:1];
  assign diam2 = 17'(cfg_i.diam2);

  // Odd-step offsets from the cell center and their squared distance.
  assign x  = $signed({1'b0, col_i, 1'b1}) - $signed({2'b00, w});
  assign y  = $signed({1'b0, row_i, 1'b1}) - $signed({2'b00, h});
  assign ax = x[8] ? 8'(-x) : x[7:0];
  assign ay = y[8] ? 8'(-y) : y[7:0];
  assign xx = 16'(ax) * 16'(ax);
  assign yy = 16'(ay) * 16'(ay);
  assign dist2 = {1'b0, xx} + {1'b0, yy};

  assign in_rect = (col_i < w) && (row_i < h);

  // Checkerboard parity; a one-pixel-wide sieve round flips it.
  assign parity = col_i[0] ^ row_i[0] ^ (w == bsm_pkg::SizeW'(1));

  // Anti-diagonal columns; negative values wrap above any valid column.
  assign slash_col = {1'b0, w} - {1'b0, row_i} - 8'd1;
  assign cross_col = {1'b0, h} - {1'b0, row_i} - 8'd1;

  // Manhattan distance from the diamond center.
  assign dc   = (col_i >= {1'b0, half}) ? col_i - {1'b0, half} : {1'b0, half} - col_i;
  assign dr   = (row_i >= {1'b0, half}) ? row_i - {1'b0, half} : {1'b0, half} - row_i;
  assign dsum = {1'b0, dc} + {1'b0, dr};

  // Per-shape coverage test.
  always_comb begin
    case (cfg_i.shape)
      bsm_pkg::ShapeRound:      shape_hit = dist2 <= diam2;
      bsm_pkg::ShapeSquare:     shape_hit = 1'b1;
      bsm_pkg::ShapeSieveRound: shape_hit = parity && (dist2 < diam2);
      bsm_pkg::ShapeSieveSq:    shape_hit = ~(col_i[0] ^ row_i[0]);
      bsm_pkg::ShapePlus:       shape_hit = (col_i == {1'b0, half}) ||
                                            (row_i == {1'b0, half});
      bsm_pkg::ShapeSlash:      shape_hit = {1'b0, col_i} == slash_col;
      bsm_pkg::ShapeAntislash:  shape_hit = col_i == row_i;
      bsm_pkg::ShapeHbar:       shape_hit = row_i == '0;
      bsm_pkg::ShapeVbar:       shape_hit = col_i == '0;
      bsm_pkg::ShapeCross:      shape_hit = (col_i == row_i) ||
                                            ({1'b0, col_i} == cross_col);
      bsm_pkg::ShapeDiamond:    shape_hit = dsum <= {2'b00, half};
      bsm_pkg::ShapeNone:       shape_hit = 1'b0;
      default:                  shape_hit = 1'b0;
    endcase
  end

  assign hit_o = in_rect && shape_hit;

endmodule

`default_nettype wire

### design/brush_shape_mask.sv
// Brush shape mask: for each pixel (col_i, row_i) of the brush cell, answers
// whether the configured brush covers it. A pixel is taken on every clock
// edge with start high (busy is always low), and its mask bit is shown for
// exactly one cycle, marked by mask_valid_o; one pixel per cycle is
// sustained, with one input register and one result register around a
// single combinational evaluation stage. The receiver cannot stall the
// output, so it must take every result beat as it comes. The user must write
// shape, width and height through the cfg_* port only while no pixel is in
// flight; the block does not enforce it. Widths and heights of 0 act as 1.

`default_nettype none

module brush_shape_mask (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [bsm_pkg::CoordW-1:0]     col_i,
  input  wire logic [bsm_pkg::CoordW-1:0]     row_i,
  output logic                                mask_valid_o,
  output logic                                mask_bit_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [bsm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [bsm_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  bsm_pkg::bsm_cfg_t            cfg;
  logic [bsm_pkg::CoordW-1:0]   col_q;
  logic [bsm_pkg::CoordW-1:0]   row_q;
  logic                         in_vld_q;
  logic                         hit;
  logic                         out_vld_q;
  logic                         out_bit_q;

  // The pipeline never stalls.
  assign busy = 1'b0;

  bsm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      col_q <= col_i;
      row_q <= row_i;
    end
  end

  bsm_eval u_eval (
    .col_i (col_q),
    .row_i (row_q),
    .cfg_i (cfg),
    .hit_o (hit)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      out_bit_q <= hit;
    end
  end

  assign mask_valid_o = out_vld_q;
  assign mask_bit_o   = out_bit_q;

endmodule

`default_nettype wire

### design/bsm_checker.sv
`default_nettype none

module bsm_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  input  wire logic                           busy,
  input  wire logic [bsm_pkg::CoordW-1:0]     col_i,
  input  wire logic [bsm_pkg::CoordW-1:0]     row_i,
  input  wire logic                           mask_valid_o,
  input  wire logic                           mask_bit_o,
  input  wire logic                           cfg_we_i
);

  // Every pixel taken yields exactly one result beat, through the input and result registers.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> ##1 mask_valid_o)
    else $error("missing result beat for an accepted pixel");

  // No result beat without a pixel taken ahead of it through the input register.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |=> ##1 !mask_valid_o)
    else $error("result beat without an accepted pixel");

  // The last column lies outside any brush, so it never reads as covered.
  a_edge_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && col_i == 7'h7f) |=> ##1 !mask_bit_o)
    else $error("pixel beyond the widest brush reported as covered");

  // Same for the last row.
  a_edge_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && row_i == 7'h7f) |=> ##1 !mask_bit_o)
    else $error("pixel beyond the tallest brush reported as covered");

  // The pipeline never pushes back on the sender.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start || cfg_we_i) |-> !busy)
    else $error("busy raised");

endmodule

bind brush_shape_mask bsm_checker u_bsm_checker (.*);

`default_nettype wire
